### hw/rtl/spsp_pkg.sv
// ----------------------------------------------------------------------------
// spsp_pkg
// Shared types and constants of the superpixel seed placement block.
// ----------------------------------------------------------------------------
package spsp_pkg;

   localparam int DEF_MAX_WIDTH          = 128;
   localparam int DEF_MAX_HEIGHT         = 128;
   localparam int DEF_MAX_CELLS_PER_SIDE = 32;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // internal coordinate width, covers dimensions up to 4095
   localparam int COORD_W = 12;
   localparam int SCORE_W = 11;
   localparam int BEST_W  = 18;

   localparam logic OP_WRITE  = 1'b0;
   localparam logic OP_SEARCH = 1'b1;

   localparam logic [1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_IMAGE_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_PATCH_SIZE   = 2'd2;

   typedef struct packed {
      logic       operation;
      logic [6:0] pixel_x;
      logic [6:0] pixel_y;
      logic [7:0] gray_value;
      logic [4:0] cell_col;
      logic [4:0] cell_row;
   } item_type;

   typedef struct packed {
      logic [7:0] image_width;
      logic [7:0] image_height;
      logic [6:0] patch_size;
   } cfg_type;

endpackage

### hw/rtl/spsp_front.sv
// ----------------------------------------------------------------------------
// spsp_front
// Accepts commands and holds them in a short queue for the search engine.
// ----------------------------------------------------------------------------
module spsp_front
   import spsp_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   input  item_type push_item,
   output logic     busy,
   input  logic     pop,
   output logic     pop_valid,
   output item_type pop_item
);

   item_type            queue_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                push, do_pop;

   assign busy      = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_item  = queue_ff[rd_ptr_ff];
   assign push      = start && !busy;
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = push   ? QPTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? QPTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !do_pop) begin
         count_in = QCNT_W'(count_ff + 1'b1);
      end else if (do_pop && !push) begin
         count_in = QCNT_W'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

### hw/rtl/spsp_search.sv
// ----------------------------------------------------------------------------
// spsp_search
// Image store and seed search sequencer: executes pixel writes and walks
// the search window, scoring each pixel against its eight neighbors.
// ----------------------------------------------------------------------------
module spsp_search
   import spsp_pkg::*;
#(
   parameter int MAX_WIDTH          = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT         = DEF_MAX_HEIGHT,
   parameter int MAX_CELLS_PER_SIDE = DEF_MAX_CELLS_PER_SIDE
)
(
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       item_valid,
   input  item_type   item,
   output logic       item_pop,
   output logic       rsp_valid,
   output logic [6:0] rsp_seed_x,
   output logic [6:0] rsp_seed_y,
   output logic       rsp_cell_outside
);

   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW    = $clog2(DEPTH);

   typedef enum logic [2:0] {
      S_IDLE, S_GRID, S_WIN, S_BASE, S_SCAN
   } state_type;

   state_type             state_ff;
   logic [4:0]            cc_ff, cr_ff;
   logic [COORD_W-1:0]    gx_ff, gy_ff, w_ff, h_ff;
   logic [3:0]            d_ff;
   logic [COORD_W-1:0]    sx_ff, ex_ff, ey_ff, x_ff, y_ff;
   logic [AW-1:0]         base_ff, row_base_ff;
   logic [3:0]            ph_ff;
   logic [7:0]            center_ff, rd_ff;
   logic [SCORE_W-1:0]    score_ff;
   logic [BEST_W-1:0]     best_ff;
   logic [COORD_W-1:0]    best_x_ff, best_y_ff;
   logic                  rsp_valid_ff, rsp_outside_ff;
   logic [6:0]            rsp_x_ff, rsp_y_ff;

   logic [7:0]            mem [DEPTH];
   logic                  mem_we;
   logic [AW-1:0]         mem_waddr, mem_raddr;
   logic signed [AW:0]    offset;

   logic [COORD_W-1:0]    w_clamp, h_clamp;
   logic [6:0]            p_clamp;
   logic [5:0]            spacing;
   logic [3:0]            d_val;
   logic [COORD_W-1:0]    gx_calc, gy_calc;
   logic                  outside_calc;
   logic [COORD_W-1:0]    sx_calc, ex_calc, sy_calc, ey_calc;
   logic [4:0]            span;
   logic [9:0]            span_sq;
   logic [BEST_W-1:0]     best_init;
   logic [7:0]            diff;
   logic [SCORE_W-1:0]    total;

   assign item_pop = (state_ff == S_IDLE) && item_valid;

   // configuration saturation
   always_comb begin
      w_clamp = COORD_W'(cfg.image_width);
      if (cfg.image_width < 8'd3) begin
         w_clamp = COORD_W'(3);
      end else if (32'(cfg.image_width) > MAX_WIDTH) begin
         w_clamp = COORD_W'(MAX_WIDTH);
      end
      h_clamp = COORD_W'(cfg.image_height);
      if (cfg.image_height < 8'd3) begin
         h_clamp = COORD_W'(3);
      end else if (32'(cfg.image_height) > MAX_HEIGHT) begin
         h_clamp = COORD_W'(MAX_HEIGHT);
      end
      p_clamp = cfg.patch_size;
      if (cfg.patch_size < 7'd8) begin
         p_clamp = 7'd8;
      end else if (cfg.patch_size > 7'd64) begin
         p_clamp = 7'd64;
      end
      spacing = p_clamp[6:1];
      d_val   = 4'(p_clamp[6:2] - 5'd1);
      gx_calc = (COORD_W'(cc_ff) + COORD_W'(1)) * COORD_W'(spacing);
      gy_calc = (COORD_W'(cr_ff) + COORD_W'(1)) * COORD_W'(spacing);
      outside_calc = (32'(cc_ff) >= MAX_CELLS_PER_SIDE)
                  || (32'(cr_ff) >= MAX_CELLS_PER_SIDE)
                  || (gx_calc >= w_clamp) || (gy_calc >= h_clamp);
   end

   // window bounds and the initial best score
   always_comb begin
      sx_calc = (gx_ff < COORD_W'(d_ff) + COORD_W'(2)) ? COORD_W'(1)
                                                       : gx_ff - COORD_W'(d_ff);
      sy_calc = (gy_ff < COORD_W'(d_ff) + COORD_W'(2)) ? COORD_W'(1)
                                                       : gy_ff - COORD_W'(d_ff);
      ex_calc = gx_ff + COORD_W'(d_ff);
      if (ex_calc > w_ff - COORD_W'(2)) begin
         ex_calc = w_ff - COORD_W'(2);
      end
      ey_calc = gy_ff + COORD_W'(d_ff);
      if (ey_calc > h_ff - COORD_W'(2)) begin
         ey_calc = h_ff - COORD_W'(2);
      end
      span      = {d_ff, 1'b1};
      span_sq   = 10'(span) * 10'(span);
      best_init = (BEST_W'(span_sq) << 8) - BEST_W'(span_sq);
   end

   // neighbor order: center first, then the eight around it
   always_comb begin
      case (ph_ff)
         4'd1:    offset = (AW+1)'(-MAX_WIDTH - 1);
         4'd2:    offset = (AW+1)'(-MAX_WIDTH);
         4'd3:    offset = (AW+1)'(-MAX_WIDTH + 1);
         4'd4:    offset = (AW+1)'(-1);
         4'd5:    offset = (AW+1)'(1);
         4'd6:    offset = (AW+1)'(MAX_WIDTH - 1);
         4'd7:    offset = (AW+1)'(MAX_WIDTH);
         4'd8:    offset = (AW+1)'(MAX_WIDTH + 1);
         default: offset = '0;
      endcase
      mem_raddr = AW'($signed({1'b0, base_ff}) + offset);
      diff      = (center_ff > rd_ff) ? center_ff - rd_ff : rd_ff - center_ff;
      total     = score_ff + SCORE_W'(diff);
   end

   assign mem_we    = item_pop && (item.operation == OP_WRITE)
                   && (32'(item.pixel_x) < MAX_WIDTH)
                   && (32'(item.pixel_y) < MAX_HEIGHT);
   assign mem_waddr = AW'(32'(item.pixel_y) * MAX_WIDTH + 32'(item.pixel_x));

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= item.gray_value;
      end
      rd_ff <= mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         ph_ff        <= '0;
      end else begin
         rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (item_pop && item.operation == OP_SEARCH) begin
                  cc_ff    <= item.cell_col;
                  cr_ff    <= item.cell_row;
                  state_ff <= S_GRID;
               end
            end
            S_GRID: begin
               gx_ff <= gx_calc;
               gy_ff <= gy_calc;
               w_ff  <= w_clamp;
               h_ff  <= h_clamp;
               d_ff  <= d_val;
               if (outside_calc) begin
                  rsp_valid_ff   <= 1'b1;
                  rsp_outside_ff <= 1'b1;
                  rsp_x_ff       <= '0;
                  rsp_y_ff       <= '0;
                  state_ff       <= S_IDLE;
               end else begin
                  state_ff <= S_WIN;
               end
            end
            S_WIN: begin
               sx_ff     <= sx_calc;
               ex_ff     <= ex_calc;
               ey_ff     <= ey_calc;
               x_ff      <= sx_calc;
               y_ff      <= sy_calc;
               best_ff   <= best_init;
               best_x_ff <= gx_ff;
               best_y_ff <= gy_ff;
               state_ff  <= S_BASE;
            end
            S_BASE: begin
               row_base_ff <= AW'(32'(y_ff) * MAX_WIDTH + 32'(x_ff));
               base_ff     <= AW'(32'(y_ff) * MAX_WIDTH + 32'(x_ff));
               ph_ff       <= '0;
               state_ff    <= S_SCAN;
            end
            S_SCAN: begin
               if (ph_ff == 4'd1) begin
                  center_ff <= rd_ff;
                  score_ff  <= '0;
               end else if (ph_ff != 4'd0 && ph_ff != 4'd9) begin
                  score_ff <= total;
               end
               if (ph_ff == 4'd9) begin
                  ph_ff <= '0;
                  if (BEST_W'(total) < best_ff) begin
                     best_ff   <= BEST_W'(total);
                     best_x_ff <= x_ff;
                     best_y_ff <= y_ff;
                  end
                  if (x_ff == ex_ff) begin
                     if (y_ff == ey_ff) begin
                        rsp_valid_ff   <= 1'b1;
                        rsp_outside_ff <= 1'b0;
                        if (BEST_W'(total) < best_ff) begin
                           rsp_x_ff <= x_ff[6:0];
                           rsp_y_ff <= y_ff[6:0];
                        end else begin
                           rsp_x_ff <= best_x_ff[6:0];
                           rsp_y_ff <= best_y_ff[6:0];
                        end
                        state_ff <= S_IDLE;
                     end else begin
                        y_ff        <= COORD_W'(y_ff + 1'b1);
                        x_ff        <= sx_ff;
                        row_base_ff <= AW'(row_base_ff + AW'(MAX_WIDTH));
                        base_ff     <= AW'(row_base_ff + AW'(MAX_WIDTH));
                     end
                  end else begin
                     x_ff    <= COORD_W'(x_ff + 1'b1);
                     base_ff <= AW'(base_ff + 1'b1);
                  end
               end else begin
                  ph_ff <= 4'(ph_ff + 1'b1);
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_seed_x       = rsp_x_ff;
   assign rsp_seed_y       = rsp_y_ff;
   assign rsp_cell_outside = rsp_outside_ff;

endmodule

### hw/rtl/superpixel_seed_placement.sv
// ----------------------------------------------------------------------------
// superpixel_seed_placement
// Grayscale frame store with lowest-gradient seed search per grid cell.
// ----------------------------------------------------------------------------
// A pixel write is taken while the search engine is idle, and writes then
// follow back to back. A seed search walks its clipped window one pixel at a
// time, one store read per cycle through the single read port; the largest
// window is 31 by 31. A cell outside the image is answered from the grid
// state without a window walk. Commands wait in a four-entry queue; busy is
// high while it is full. Each result is shown for one cycle on rsp_valid and
// must be taken then. Load the whole frame before the first search.
module superpixel_seed_placement
   import spsp_pkg::*;
#(
   parameter int MAX_WIDTH          = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT         = DEF_MAX_HEIGHT,
   parameter int MAX_CELLS_PER_SIDE = DEF_MAX_CELLS_PER_SIDE
)
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic       req_operation,
   input  logic [6:0] req_pixel_x,
   input  logic [6:0] req_pixel_y,
   input  logic [7:0] req_gray_value,
   input  logic [4:0] req_cell_col,
   input  logic [4:0] req_cell_row,
   output logic       rsp_valid,
   output logic [6:0] rsp_seed_x,
   output logic [6:0] rsp_seed_y,
   output logic       rsp_cell_outside,
   input  logic       csr_write_enable,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_write_data
);

   cfg_type  cfg_ff;
   item_type push_item, pop_item;
   logic     pop_valid, pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.image_width  <= 8'd128;
         cfg_ff.image_height <= 8'd128;
         cfg_ff.patch_size   <= 7'd16;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:  cfg_ff.image_width  <= csr_write_data;
            CSR_IMAGE_HEIGHT: cfg_ff.image_height <= csr_write_data;
            CSR_PATCH_SIZE:   cfg_ff.patch_size   <= csr_write_data[6:0];
            default: ;
         endcase
      end
   end

   assign push_item = '{operation:  req_operation,
                        pixel_x:    req_pixel_x,
                        pixel_y:    req_pixel_y,
                        gray_value: req_gray_value,
                        cell_col:   req_cell_col,
                        cell_row:   req_cell_row};

   spsp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .push_item (push_item),
      .busy      (busy),
      .pop       (pop),
      .pop_valid (pop_valid),
      .pop_item  (pop_item)
   );

   spsp_search #(
      .MAX_WIDTH          (MAX_WIDTH),
      .MAX_HEIGHT         (MAX_HEIGHT),
      .MAX_CELLS_PER_SIDE (MAX_CELLS_PER_SIDE)
   ) u_search (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .item_valid       (pop_valid),
      .item             (pop_item),
      .item_pop         (pop),
      .rsp_valid        (rsp_valid),
      .rsp_seed_x       (rsp_seed_x),
      .rsp_seed_y       (rsp_seed_y),
      .rsp_cell_outside (rsp_cell_outside)
   );

   a_rsp_single : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("back-to-back result strobes");

   a_outside_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_cell_outside |-> rsp_seed_x == 7'd0 && rsp_seed_y == 7'd0)
      else $error("outside cell with nonzero seed");

   a_reset_clear : assert property (@(posedge clock)
      $past(reset) |-> !busy && !rsp_valid)
      else $error("busy or result after reset");

endmodule
